FILE: src/eye_gesture_window_classifier_macros.svh
// ----------------------------------------------------------------------------
// Eye gesture window classifier assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef EYE_GESTURE_WINDOW_CLASSIFIER_MACROS_SVH
`define EYE_GESTURE_WINDOW_CLASSIFIER_MACROS_SVH

// Same-cycle implication, reports through $error.
`define EGWC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reports through $error.
`define EGWC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/egwc_pkg.sv
// ----------------------------------------------------------------------------
// Eye gesture window classifier package
// Shared types, codes and constants for the classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package egwc_pkg;

   // Default window lengths in frames.
   localparam int SHORT_WINDOW_DEF = 5;
   localparam int LONG_WINDOW_DEF  = 15;

   // Configuration register widths and reset values.
   localparam int              SHORT_NEED_W   = 3;
   localparam int              LONG_NEED_W    = 4;
   localparam logic [2:0]      SHORT_NEED_RST = 3'd4;
   localparam logic [3:0]      LONG_NEED_RST  = 4'd10;
   localparam int              CSR_ADDR_W     = 3;
   localparam int              CSR_DATA_W     = 32;

   // Register indexes, taken from address bit 2.
   localparam logic REG_SHORT_NEED = 1'b0;
   localparam logic REG_LONG_NEED  = 1'b1;

   // Pupil pattern of one frame: bit 0 left, bit 1 right.
   typedef logic [1:0] pat_type;
   localparam int      NUM_PAT   = 4;
   localparam pat_type PAT_NONE  = 2'd0;
   localparam pat_type PAT_LEFT  = 2'd1;
   localparam pat_type PAT_RIGHT = 2'd2;
   localparam pat_type PAT_BOTH  = 2'd3;

   typedef enum logic [2:0] {
      MODE_ACTIVE = 3'd0,
      MODE_ALERT  = 3'd1,
      MODE_TLEFT  = 3'd2,
      MODE_TRIGHT = 3'd3,
      MODE_WLEFT  = 3'd4,
      MODE_WRIGHT = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_ALERT      = 3'd1,
      EV_LEFT_DONE  = 3'd2,
      EV_RIGHT_DONE = 3'd3,
      EV_RETURN     = 3'd4
   } event_type;

   // Majority check results, one bit per pattern for each window.
   typedef struct packed {
      logic [NUM_PAT-1:0] short_hit;
      logic [NUM_PAT-1:0] long_hit;
   } checks_type;

endpackage

`default_nettype wire

FILE: src/eye_gesture_window_classifier.sv
// Throughput: one frame per cycle while the skid register is empty; results
// are registered in the main or skid register. The history chain, running
// window counts and the mode machine all update in the accept cycle.
// Reset: synchronous, active high; the history fills with both-pupils-present,
// the mode returns to active and the needs return to 4 and 10.
// ----------------------------------------------------------------------------
// Eye gesture window classifier
// Pushes each frame's pupil flags into a chain of history cells, keeps
// running pattern counts over a short and a long window, and runs a six-mode
// gesture machine on the majority checks.
// ----------------------------------------------------------------------------
`default_nettype none

module eye_gesture_window_classifier
   import egwc_pkg::*;
#(
   parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
   parameter int LONG_WINDOW  = LONG_WINDOW_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_left_present,
   input  wire logic                  req_right_present,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_mode,
   output logic [2:0]                 rsp_event_code,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // The short window never reaches past the end of the history.
   localparam int SW_EFF = (SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;

   // ------------------------------------------------------------------
   // Configuration registers. Address bit 2 selects the register, so
   // every write lands on one of the two needs.
   // ------------------------------------------------------------------
   logic [SHORT_NEED_W-1:0] short_need_ff;
   logic [LONG_NEED_W-1:0]  long_need_ff;
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_need_ff <= SHORT_NEED_RST;
         long_need_ff  <= LONG_NEED_RST;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_SHORT_NEED) begin
            short_need_ff <= csr_pwdata[SHORT_NEED_W-1:0];
         end else begin
            long_need_ff <= csr_pwdata[LONG_NEED_W-1:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SHORT_NEED: csr_prdata = CSR_DATA_W'(short_need_ff);
         REG_LONG_NEED:  csr_prdata = CSR_DATA_W'(long_need_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Input handshake. The output side is a main register plus a skid
   // register, so a frame is taken while a finished result still waits.
   // The input stalls only when the skid register is occupied.
   // ------------------------------------------------------------------
   logic    advance;
   pat_type new_pat;

   assign advance = req_valid && !req_stall;
   assign new_pat = {req_right_present, req_left_present};

   // ------------------------------------------------------------------
   // History chain: cell zero holds the newest frame. Each accepted
   // beat moves every pattern one cell further along.
   // ------------------------------------------------------------------
   pat_type hist [LONG_WINDOW];

   for (genvar i = 0; i < LONG_WINDOW; i++) begin : g_cell
      pat_type cell_in;
      if (i == 0) begin : g_head
         assign cell_in = new_pat;
      end else begin : g_body
         assign cell_in = hist[i-1];
      end
      egwc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .pat_in  (cell_in),
         .pat_out (hist[i])
      );
   end

   // ------------------------------------------------------------------
   // Window counts. The last cell of each window is the entry that
   // falls out of it when the new frame is pushed.
   // ------------------------------------------------------------------
   checks_type chk;

   egwc_tally #(
      .WINDOW (SW_EFF),
      .NEED_W (SHORT_NEED_W)
   ) u_short_tally (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .new_pat  (new_pat),
      .drop_pat (hist[SW_EFF-1]),
      .need     (short_need_ff),
      .hit      (chk.short_hit)
   );

   egwc_tally #(
      .WINDOW (LONG_WINDOW),
      .NEED_W (LONG_NEED_W)
   ) u_long_tally (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .new_pat  (new_pat),
      .drop_pat (hist[LONG_WINDOW-1]),
      .need     (long_need_ff),
      .hit      (chk.long_hit)
   );

   // ------------------------------------------------------------------
   // Gesture mode machine.
   // ------------------------------------------------------------------
   mode_type  mode_next;
   event_type event_code;

   egwc_gesture u_gesture (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .chk        (chk),
      .mode_next  (mode_next),
      .event_code (event_code)
   );

   // ------------------------------------------------------------------
   // Output register with skid stage. A result goes to the main register
   // when it is empty or being taken, otherwise into the skid register.
   // When the main register is taken, the skid result moves up.
   // ------------------------------------------------------------------
   logic       main_valid_ff;
   logic       skid_valid_ff;
   logic [2:0] main_mode_ff;
   logic [2:0] main_event_ff;
   logic [2:0] skid_mode_ff;
   logic [2:0] skid_event_ff;
   logic       pop;

   assign pop       = main_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (advance) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_mode_ff  <= skid_mode_ff;
            main_event_ff <= skid_event_ff;
         end
      end else if (advance) begin
         if (main_valid_ff && !pop) begin
            skid_mode_ff  <= mode_next;
            skid_event_ff <= event_code;
         end else begin
            main_mode_ff  <= mode_next;
            main_event_ff <= event_code;
         end
      end
   end

   assign rsp_valid      = main_valid_ff;
   assign rsp_mode       = main_mode_ff;
   assign rsp_event_code = main_event_ff;

endmodule

`default_nettype wire

FILE: src/egwc_cell.sv
// ----------------------------------------------------------------------------
// History cell
// Holds one frame's pupil pattern and hands it to the next cell on a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module egwc_cell
   import egwc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire pat_type pat_in,
   output pat_type      pat_out
);

   pat_type pat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff <= PAT_BOTH;
      end else if (advance) begin
         pat_ff <= pat_in;
      end
   end

   assign pat_out = pat_ff;

endmodule

`default_nettype wire

FILE: src/egwc_tally.sv
// ----------------------------------------------------------------------------
// Window tally
// Running per-pattern counts over one window of the history chain.
// ----------------------------------------------------------------------------
`default_nettype none

module egwc_tally
   import egwc_pkg::*;
#(
   parameter int WINDOW = SHORT_WINDOW_DEF,
   parameter int NEED_W = SHORT_NEED_W
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire pat_type           new_pat,
   input  wire pat_type           drop_pat,
   input  wire logic [NEED_W-1:0] need,
   output logic [NUM_PAT-1:0]     hit
);

   localparam int CW    = $clog2(WINDOW + 1);
   localparam int CMP_W = (CW > NEED_W) ? CW : NEED_W;

   logic [CW-1:0] cnt_ff [NUM_PAT];
   logic [CW-1:0] cnt_in [NUM_PAT];

   // The entry leaving the window is dropped as the new one enters.
   always_comb begin
      for (int p = 0; p < NUM_PAT; p++) begin
         cnt_in[p] = cnt_ff[p] + CW'(new_pat == pat_type'(p))
                     - CW'(drop_pat == pat_type'(p));
         hit[p]    = CMP_W'(cnt_in[p]) >= CMP_W'(need);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PAT; p++) begin
            cnt_ff[p] <= (pat_type'(p) == PAT_BOTH) ? CW'(WINDOW) : '0;
         end
      end else if (advance) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/egwc_gesture.sv
// ----------------------------------------------------------------------------
// Gesture mode machine
// Six-mode gesture state driven by the window majority checks.
// ----------------------------------------------------------------------------
`default_nettype none

module egwc_gesture
   import egwc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire checks_type chk,
   output mode_type        mode_next,
   output event_type       event_code
);

   mode_type mode_ff;
   mode_type mode_in;

   // Next state: checks in priority order, first that passes wins.
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_ACTIVE: begin
            if (chk.short_hit[PAT_NONE]) mode_in = MODE_ALERT;
            else if (chk.long_hit[PAT_RIGHT]) mode_in = MODE_TLEFT;
            else if (chk.long_hit[PAT_LEFT]) mode_in = MODE_TRIGHT;
         end
         MODE_ALERT: begin
            if (chk.short_hit[PAT_BOTH]) mode_in = MODE_ACTIVE;
         end
         MODE_TLEFT: begin
            if (chk.long_hit[PAT_RIGHT]) mode_in = MODE_ACTIVE;
            else if (chk.short_hit[PAT_NONE]) mode_in = MODE_ALERT;
            else if (chk.short_hit[PAT_BOTH]) mode_in = MODE_WRIGHT;
         end
         MODE_TRIGHT: begin
            if (chk.long_hit[PAT_LEFT]) mode_in = MODE_ACTIVE;
            else if (chk.short_hit[PAT_NONE]) mode_in = MODE_ALERT;
            else if (chk.short_hit[PAT_BOTH]) mode_in = MODE_WLEFT;
         end
         MODE_WLEFT: begin
            if (chk.short_hit[PAT_RIGHT] || chk.long_hit[PAT_BOTH]) mode_in = MODE_ACTIVE;
         end
         MODE_WRIGHT: begin
            if (chk.short_hit[PAT_LEFT] || chk.long_hit[PAT_BOTH]) mode_in = MODE_ACTIVE;
         end
         default: begin
            if (chk.short_hit[PAT_NONE]) mode_in = MODE_ALERT;
            else if (chk.long_hit[PAT_RIGHT]) mode_in = MODE_TLEFT;
            else if (chk.long_hit[PAT_LEFT]) mode_in = MODE_TRIGHT;
         end
      endcase
   end

   // Event code for the same priority order.
   always_comb begin
      event_code = EV_NONE;
      case (mode_ff)
         MODE_ACTIVE: begin
            if (chk.short_hit[PAT_NONE]) event_code = EV_ALERT;
         end
         MODE_ALERT: begin
            if (chk.short_hit[PAT_BOTH]) event_code = EV_ALERT;
         end
         MODE_TLEFT: begin
            if (chk.long_hit[PAT_RIGHT]) event_code = EV_LEFT_DONE;
            else if (chk.short_hit[PAT_NONE]) event_code = EV_ALERT;
         end
         MODE_TRIGHT: begin
            if (chk.long_hit[PAT_LEFT]) event_code = EV_RIGHT_DONE;
            else if (chk.short_hit[PAT_NONE]) event_code = EV_ALERT;
         end
         MODE_WLEFT: begin
            if (chk.short_hit[PAT_RIGHT]) event_code = EV_RETURN;
         end
         MODE_WRIGHT: begin
            if (chk.short_hit[PAT_LEFT]) event_code = EV_RETURN;
         end
         default: begin
            if (chk.short_hit[PAT_NONE]) event_code = EV_ALERT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ACTIVE;
      end else if (advance) begin
         mode_ff <= mode_in;
      end
   end

   assign mode_next = mode_in;

endmodule

`default_nettype wire

FILE: src/egwc_checker.sv
// ----------------------------------------------------------------------------
// Classifier port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "eye_gesture_window_classifier_macros.svh"

module egwc_checker
   import egwc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_mode,
   input wire logic [2:0] rsp_event_code
);

   // A waiting result holds its payload while stalled.
   `EGWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_mode) && $stable(rsp_event_code),
      "stalled result beat changed")

   // The input only stalls when a result is already waiting.
   `EGWC_ASSERT_NOW(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid,
      "input stalled with no result pending")

   // Completion and return events always land back in active mode.
   `EGWC_ASSERT_NOW(a_done_to_active, clock, reset,
      rsp_valid && (rsp_event_code == EV_LEFT_DONE || rsp_event_code == EV_RIGHT_DONE
                    || rsp_event_code == EV_RETURN),
      rsp_mode == MODE_ACTIVE, "gesture completion without active mode")

   // An alert event either raises or clears the alert.
   `EGWC_ASSERT_NOW(a_alert_mode, clock, reset,
      rsp_valid && rsp_event_code == EV_ALERT,
      rsp_mode == MODE_ALERT || rsp_mode == MODE_ACTIVE, "alert event with wrong mode")

   // Coming out of reset, nothing is pending and input is open.
   `EGWC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall,
      "output not empty after reset")

endmodule

bind eye_gesture_window_classifier egwc_checker u_egwc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_mode       (rsp_mode),
   .rsp_event_code (rsp_event_code)
);

`default_nettype wire

FILE: tb/sv/eye_gesture_window_classifier_tb.sv
// ----------------------------------------------------------------------------
// Eye gesture window classifier testbench
// Streams pupil-flag frames through the classifier under several settings of
// the two majority needs. A local model predicts the mode and event of every
// frame, and the result beats are checked against it in order.
// ----------------------------------------------------------------------------

module eye_gesture_window_classifier_tb;
   import egwc_pkg::*;

   localparam int SHORT_WIN        = SHORT_WINDOW_DEF;
   localparam int LONG_WIN         = LONG_WINDOW_DEF;
   localparam int RESET_CYCLES     = 9;
   localparam int SETTLE_CYCLES    = 3;
   localparam int DRAIN_CYCLES     = 6;
   localparam int NUM_PHASES       = 8;
   localparam int RANDOM_PER_PHASE = 70;
   localparam int HOLD_PHASE       = 4;
   localparam int LONG_HOLD        = 60;
   localparam int MAX_GAP          = 17;
   localparam int MAX_SHOWN        = 10;
   localparam int TIMEOUT_CYCLES   = 200_000;

   typedef struct packed {
      logic left;
      logic right;
   } frame_type;

   typedef struct packed {
      mode_type  mode;
      event_type ev;
   } gesture_type;

   // DUT connections. Everything the testbench drives starts at a known value.
   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic                  req_left_present  = 1'b0;
   logic                  req_right_present = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic [2:0]            rsp_mode;
   logic [2:0]            rsp_event_code;
   logic                  csr_psel          = 1'b0;
   logic                  csr_penable       = 1'b0;
   logic                  csr_pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr         = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata        = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Model state: the frame history (newest at index 0), the gesture mode and
   // the two needs as they were last written.
   pat_type    frame_hist [LONG_WIN];
   mode_type   gesture_now;
   logic [2:0] need_short = SHORT_NEED_RST;
   logic [3:0] need_long  = LONG_NEED_RST;

   // Frames waiting to be driven, and gestures waiting for their result beat.
   frame_type   frames_pending [$];
   gesture_type expected_gestures [$];

   int unsigned frames_planned = 0;
   int unsigned frames_taken   = 0;
   int unsigned results_seen   = 0;
   int unsigned settings_tried = 0;
   int unsigned fail_count     = 0;
   int unsigned event_tally [5] = '{default: 0};

   // Handshake flags seen at the last rising edge, used by the falling-edge
   // driver and receiver to learn that their beat went through.
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   // Idling controls, set per phase by the stimulus process.
   logic tx_gaps_on    = 1'b1;
   logic rx_gaps_on    = 1'b1;
   logic long_hold_arm = 1'b0;

   // Sender and receiver countdowns.
   int unsigned tx_gap          = 0;
   int unsigned rx_wait         = 0;
   int unsigned hold_left       = 0;
   logic        long_hold_taken = 1'b0;

   eye_gesture_window_classifier #(
      .SHORT_WINDOW(SHORT_WIN),
      .LONG_WINDOW (LONG_WIN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_present (req_left_present),
      .req_right_present(req_right_present),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mode         (rsp_mode),
      .rsp_event_code   (rsp_event_code),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Gesture model
   // ------------------------------------------------------------------------

   // Number of frames among the newest span that carry pattern p. A span
   // longer than the history is cut to the history length.
   function automatic int unsigned window_hits(int unsigned span, pat_type p);
      int unsigned hits = 0;
      int unsigned lim;
      lim = (span > LONG_WIN) ? LONG_WIN : span;
      for (int unsigned i = 0; i < lim; i++) begin
         if (frame_hist[i] == p) begin
            hits++;
         end
      end
      return hits;
   endfunction

   // A need of zero always passes; a need above the window never does, which
   // falls out of the plain comparison.
   function automatic logic short_hit(pat_type p);
      return window_hits(SHORT_WIN, p) >= int'(need_short);
   endfunction

   function automatic logic long_hit(pat_type p);
      return window_hits(LONG_WIN, p) >= int'(need_long);
   endfunction

   // Pushes one frame into the history, then steps the mode machine. The
   // checks in each mode are tried in priority order and the first one that
   // passes decides the move.
   function automatic gesture_type advance_gesture(logic left, logic right);
      gesture_type res;
      for (int i = LONG_WIN - 1; i > 0; i--) begin
         frame_hist[i] = frame_hist[i-1];
      end
      frame_hist[0] = {right, left};
      res.mode = gesture_now;
      res.ev   = EV_NONE;
      case (gesture_now)
         MODE_ALERT: begin
            if (short_hit(PAT_BOTH)) begin
               res.mode = MODE_ACTIVE; res.ev = EV_ALERT;
            end
         end
         MODE_WLEFT: begin
            if (short_hit(PAT_RIGHT)) begin
               res.mode = MODE_ACTIVE; res.ev = EV_RETURN;
            end else if (long_hit(PAT_BOTH)) begin
               res.mode = MODE_ACTIVE;
            end
         end
         MODE_WRIGHT: begin
            if (short_hit(PAT_LEFT)) begin
               res.mode = MODE_ACTIVE; res.ev = EV_RETURN;
            end else if (long_hit(PAT_BOTH)) begin
               res.mode = MODE_ACTIVE;
            end
         end
         MODE_TLEFT: begin
            if (long_hit(PAT_RIGHT)) begin
               res.mode = MODE_ACTIVE; res.ev = EV_LEFT_DONE;
            end else if (short_hit(PAT_NONE)) begin
               res.mode = MODE_ALERT; res.ev = EV_ALERT;
            end else if (short_hit(PAT_BOTH)) begin
               res.mode = MODE_WRIGHT;
            end
         end
         MODE_TRIGHT: begin
            if (long_hit(PAT_LEFT)) begin
               res.mode = MODE_ACTIVE; res.ev = EV_RIGHT_DONE;
            end else if (short_hit(PAT_NONE)) begin
               res.mode = MODE_ALERT; res.ev = EV_ALERT;
            end else if (short_hit(PAT_BOTH)) begin
               res.mode = MODE_WLEFT;
            end
         end
         default: begin
            if (short_hit(PAT_NONE)) begin
               res.mode = MODE_ALERT; res.ev = EV_ALERT;
            end else if (long_hit(PAT_RIGHT)) begin
               res.mode = MODE_TLEFT;
            end else if (long_hit(PAT_LEFT)) begin
               res.mode = MODE_TRIGHT;
            end
         end
      endcase
      gesture_now = res.mode;
      event_tally[int'(res.ev)]++;
      return res;
   endfunction

   // Every failure goes through here. Only the first few are printed.
   function automatic void flag_error(input string msg);
      if (fail_count < MAX_SHOWN) begin
         $display("ERROR: %s", msg);
      end
      fail_count++;
   endfunction

   // ------------------------------------------------------------------------
   // Frame driver
   // ------------------------------------------------------------------------
   // Works on the falling edge. Once a beat has gone through it draws a gap
   // for the next frame when gaps are on, counts the gap down while the line
   // is idle, and then presents the next pending frame. A frame that is
   // offered stays put until it is taken.
   always @(negedge clock) begin : frame_driver
      int unsigned gap;
      frame_type   nxt;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap    <= 0;
      end else if (!req_valid || req_fired) begin
         gap = tx_gap;
         if (req_fired && tx_gaps_on) begin
            gap = $urandom_range(0, MAX_GAP);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            tx_gap    <= gap - 1;
         end else if (frames_pending.size() != 0) begin
            nxt = frames_pending.pop_front();
            req_valid         <= 1'b1;
            req_left_present  <= nxt.left;
            req_right_present <= nxt.right;
            tx_gap            <= 0;
         end else begin
            req_valid <= 1'b0;
            tx_gap    <= 0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver
   // ------------------------------------------------------------------------
   // After every result beat, when gaps are on, it draws how long to stall
   // before the next one. Once per run it also holds the channel for a long
   // stretch, counted here, while the driver keeps offering frames; the main
   // and skid result registers fill and the block has to stall its input.
   always @(negedge clock) begin : result_receiver
      int unsigned wait_draw;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait   <= 0;
         hold_left <= 0;
      end else begin
         wait_draw = rx_wait;
         if (rsp_fired && rx_gaps_on) begin
            wait_draw = $urandom_range(0, MAX_GAP);
         end
         if (long_hold_arm && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD - 1;
            rsp_stall       <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (wait_draw != 0) begin
            rx_wait   <= wait_draw - 1;
            rsp_stall <= 1'b1;
         end else begin
            rx_wait   <= 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------------
   // Samples both channels on the rising edge. An accepted frame beat steps the
   // model and queues its gesture; an accepted result beat is compared with
   // the oldest queued gesture, field by field.
   always @(posedge clock) begin : beat_monitor
      gesture_type want;
      if (reset) begin
         for (int i = 0; i < LONG_WIN; i++) begin
            frame_hist[i] = PAT_BOTH;
         end
         gesture_now = MODE_ACTIVE;
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         rsp_fired <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            expected_gestures.push_back(advance_gesture(req_left_present,
                                                        req_right_present));
            frames_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_gestures.size() == 0) begin
               flag_error($sformatf("result beat %0d (mode %0d, event %0d) with no frame behind it",
                                    results_seen, rsp_mode, rsp_event_code));
            end else begin
               want = expected_gestures.pop_front();
               if (rsp_mode !== want.mode) begin
                  flag_error($sformatf("result beat %0d: mode %0d, expected %0d (%s)",
                                       results_seen, rsp_mode, want.mode, want.mode.name()));
               end
               if (rsp_event_code !== want.ev) begin
                  flag_error($sformatf("result beat %0d: event %0d, expected %0d (%s)",
                                       results_seen, rsp_event_code, want.ev, want.ev.name()));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Register access
   // ------------------------------------------------------------------------
   // One APB transfer: setup phase, then access phase until pready.
   task automatic csr_access(input logic reg_idx, input logic wr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_need(input logic reg_idx, input logic [3:0] want);
      logic [CSR_DATA_W-1:0] back;
      csr_access(reg_idx, 1'b0, '0, back);
      if (back !== CSR_DATA_W'(want)) begin
         flag_error($sformatf("register %0d reads %0h, expected %0h", reg_idx, back, want));
      end
   endtask

   // Writes a need with random junk in the bits above the register, which the
   // block must drop, updates the model and reads the register back.
   task automatic set_need(input logic reg_idx, input logic [3:0] value);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] back;
      logic [3:0]            kept;
      word = $urandom();
      if (reg_idx == REG_SHORT_NEED) begin
         word[2:0] = value[2:0];
         kept      = {1'b0, value[2:0]};
      end else begin
         word[3:0] = value;
         kept      = value;
      end
      csr_access(reg_idx, 1'b1, word, back);
      if (reg_idx == REG_SHORT_NEED) begin
         need_short = kept[2:0];
      end else begin
         need_long = kept;
      end
      check_need(reg_idx, kept);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_run(input pat_type p, input int unsigned n);
      frame_type f;
      f.left  = p[0];
      f.right = p[1];
      for (int unsigned i = 0; i < n; i++) begin
         frames_pending.push_back(f);
      end
      frames_planned += n;
   endtask

   // Four draws in ten are gesture-shaped: a head turn (one pupil lost for a
   // while), a short look back, a second stretch of the turn, a return to both
   // pupils and a glance to either side. Random lengths put the counts around
   // the needs. The rest is plain runs of one pattern and single noisy frames.
   task automatic queue_mix(input int unsigned count);
      int unsigned start;
      pat_type     turn;
      pat_type     away;
      start = frames_planned;
      while (frames_planned - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               turn = $urandom_range(0, 1) ? PAT_RIGHT : PAT_LEFT;
               away = (turn == PAT_RIGHT) ? PAT_LEFT : PAT_RIGHT;
               queue_run(turn, $urandom_range(3, 11));
               queue_run(away, $urandom_range(0, 6));
               queue_run(turn, $urandom_range(2, 8));
               queue_run(PAT_BOTH, $urandom_range(2, 6));
               queue_run($urandom_range(0, 1) ? away : turn, $urandom_range(1, 6));
            end
            4, 5, 6, 7: begin
               queue_run(pat_type'($urandom_range(0, NUM_PAT - 1)), $urandom_range(1, 12));
            end
            default: begin
               queue_run(pat_type'($urandom_range(0, NUM_PAT - 1)), 1);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (frames_taken != frames_planned || expected_gestures.size() != 0);
   endtask

   // Main sequence. The needs change only while nothing is in flight. Each
   // phase picks a setting, then a sender and receiver idling style, then
   // queues its frames. The settings include both extremes: needs of zero
   // (every check passes, so the mode flips between active and alert), and a
   // short need above the short window together with a long need equal to the
   // long window.
   initial begin : stimulus
      int unsigned phase;
      logic [2:0]  s_val;
      logic [3:0]  l_val;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Both needs must come out of reset at their documented values.
      check_need(REG_SHORT_NEED, {1'b0, SHORT_NEED_RST});
      check_need(REG_LONG_NEED, LONG_NEED_RST);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(negedge clock);
         case (phase)
            0: begin s_val = SHORT_NEED_RST; l_val = LONG_NEED_RST; end
            1: begin s_val = 3'd0;           l_val = 4'd0;          end
            2: begin s_val = 3'd7;           l_val = 4'd15;         end
            3: begin s_val = 3'd1;           l_val = 4'd1;          end
            4: begin s_val = 3'd5;           l_val = 4'd15;         end
            5: begin s_val = 3'd3;           l_val = 4'd12;         end
            default: begin
               s_val = 3'($urandom_range(0, 7));
               l_val = 4'($urandom_range(0, 15));
            end
         endcase
         set_need(REG_SHORT_NEED, {1'b0, s_val});
         set_need(REG_LONG_NEED, l_val);
         settings_tried++;

         @(posedge clock);
         tx_gaps_on = (phase % 3) != 1;
         rx_gaps_on = (phase % 3) != 2;

         // Directed opening at the reset needs: right-only, left-only and
         // right-only stretches bring the long right count to ten just as the
         // oldest right frame sits at the end of the history, so the mode turns
         // left; both pupils then drop that count and lead to wait-right, and
         // the left-only glance closes the return gesture. Two frames with no
         // pupil finish it.
         if (phase == 0) begin
            queue_run(PAT_RIGHT, 5);
            queue_run(PAT_LEFT, 5);
            queue_run(PAT_RIGHT, 5);
            queue_run(PAT_BOTH, 4);
            queue_run(PAT_LEFT, 4);
            queue_run(PAT_NONE, 2);
         end
         if (phase == HOLD_PHASE) begin
            long_hold_arm = 1'b1;
         end
         queue_mix(RANDOM_PER_PHASE);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_gestures.size() != 0) begin
         flag_error($sformatf("%0d expected results never arrived",
                              expected_gestures.size()));
      end

      $display("Ran %0d frames through %0d need settings; %0d result beats checked.",
               frames_taken, settings_tried, results_seen);
      $display("Events seen: %0d alert, %0d left done, %0d right done, %0d return; %0d errors.",
               event_tally[EV_ALERT], event_tally[EV_LEFT_DONE],
               event_tally[EV_RIGHT_DONE], event_tally[EV_RETURN], fail_count);
      if (fail_count == 0) begin
         $display("eye_gesture_window_classifier verification clean");
      end else begin
         $display("eye_gesture_window_classifier verification failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * 8);
      $display("Timed out with %0d of %0d frames taken and %0d results pending.",
               frames_taken, frames_planned, expected_gestures.size());
      $display("eye_gesture_window_classifier verification failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/egwc_pkg.sv
src/egwc_cell.sv
src/egwc_tally.sv
src/egwc_gesture.sv
src/eye_gesture_window_classifier.sv
src/egwc_checker.sv
tb/sv/eye_gesture_window_classifier_tb.sv
